FILE: src/bbht_pkg.sv
package bbht_pkg;
    localparam int MAX_LEVEL_DEF   = 8;
    localparam int COORD_WIDTH_DEF = 24;
    localparam int LEVEL_W         = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_BOTTOM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_RIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;      // take input curve, level from limit
        logic bbox;      // register bounding box of current piece
        logic split;     // current <- left half, push right half
        logic pop;       // current <- top of stack
    } bbht_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic disjoint;
        logic contained;
        logic level_zero;
        logic stack_empty;
    } bbht_stat_t;
endpackage

FILE: src/bbht_datapath.sv
module bbht_datapath #(
    parameter int MAX_LEVEL   = bbht_pkg::MAX_LEVEL_DEF,
    parameter int COORD_WIDTH = bbht_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bbht_pkg::bbht_cmd_t           cmd,
    output bbht_pkg::bbht_stat_t          stat,
    input  logic signed [COORD_WIDTH-1:0] in_pt [8],
    input  logic signed [COORD_WIDTH-1:0] box_left,
    input  logic signed [COORD_WIDTH-1:0] box_bottom,
    input  logic signed [COORD_WIDTH-1:0] box_right,
    input  logic signed [COORD_WIDTH-1:0] box_top,
    input  logic [bbht_pkg::LEVEL_W-1:0]  depth_limit
);
    import bbht_pkg::*;

    localparam int DEPTH = (MAX_LEVEL > 0) ? MAX_LEVEL : 1;
    localparam int SP_W  = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = 8 * COORD_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] crd_t;

    crd_t cur_reg [8];       // x0 y0 x1 y1 x2 y2 x3 y3
    logic [LEVEL_W-1:0] level_reg;
    logic [SP_W-1:0]    sp_reg;
    crd_t bx0_reg, bx1_reg, by0_reg, by1_reg;

    logic [PW-1:0]      halves_mem [DEPTH];
    logic [LEVEL_W-1:0] levels_mem [DEPTH];

    function automatic crd_t mid(input crd_t a, input crd_t b);
        logic signed [COORD_WIDTH:0] s;
        begin
            s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
            mid = s[COORD_WIDTH:1];
        end
    endfunction

    function automatic crd_t mn(input crd_t a, input crd_t b);
        mn = (a < b) ? a : b;
    endfunction

    function automatic crd_t mx(input crd_t a, input crd_t b);
        mx = (a > b) ? a : b;
    endfunction

    // de Casteljau split, per coordinate
    crd_t lo [8];
    crd_t hi [8];
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            crd_t a, b, d, e, f, g;
            a = mid(cur_reg[k],   cur_reg[2+k]);
            b = mid(cur_reg[2+k], cur_reg[4+k]);
            d = mid(cur_reg[4+k], cur_reg[6+k]);
            e = mid(a, b);
            f = mid(b, d);
            g = mid(e, f);
            lo[k] = cur_reg[k]; lo[2+k] = a; lo[4+k] = e; lo[6+k] = g;
            hi[k] = g; hi[2+k] = f; hi[4+k] = d; hi[6+k] = cur_reg[6+k];
        end
    end

    logic [PW-1:0] hi_flat, top_flat;
    always_comb begin
        for (int k = 0; k < 8; k++) hi_flat[k*COORD_WIDTH +: COORD_WIDTH] = hi[k];
    end

    logic [IDX_W-1:0] top_idx;
    assign top_idx  = IDX_W'(sp_reg - SP_W'(1));
    assign top_flat = halves_mem[top_idx];

    logic [LEVEL_W-1:0] lim;
    assign lim = (depth_limit > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) : depth_limit;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_reg   <= in_pt;
            level_reg <= lim;
        end else if (cmd.split) begin
            cur_reg   <= lo;
            level_reg <= level_reg - LEVEL_W'(1);
        end else if (cmd.pop) begin
            for (int k = 0; k < 8; k++)
                cur_reg[k] <= top_flat[k*COORD_WIDTH +: COORD_WIDTH];
            level_reg <= levels_mem[top_idx];
        end
        if (cmd.bbox) begin
            bx0_reg <= mn(mn(cur_reg[0], cur_reg[2]), mn(cur_reg[4], cur_reg[6]));
            bx1_reg <= mx(mx(cur_reg[0], cur_reg[2]), mx(cur_reg[4], cur_reg[6]));
            by0_reg <= mn(mn(cur_reg[1], cur_reg[3]), mn(cur_reg[5], cur_reg[7]));
            by1_reg <= mx(mx(cur_reg[1], cur_reg[3]), mx(cur_reg[5], cur_reg[7]));
        end
        if (cmd.split && sp_reg < SP_W'(DEPTH)) begin
            halves_mem[sp_reg[IDX_W-1:0]] <= hi_flat;
            levels_mem[sp_reg[IDX_W-1:0]] <= level_reg - LEVEL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else if (cmd.load) begin
            sp_reg <= '0;
        end else if (cmd.split && sp_reg < SP_W'(DEPTH)) begin
            sp_reg <= sp_reg + SP_W'(1);
        end else if (cmd.pop) begin
            sp_reg <= sp_reg - SP_W'(1);
        end
    end

    assign stat.disjoint = (bx1_reg < box_left) || (box_right < bx0_reg) ||
                           (by1_reg < box_bottom) || (box_top < by0_reg);
    assign stat.contained = (box_left <= bx0_reg) && (bx1_reg <= box_right) &&
                            (box_bottom <= by0_reg) && (by1_reg <= box_top);
    assign stat.level_zero  = (level_reg == '0);
    assign stat.stack_empty = (sp_reg == '0);
endmodule

FILE: src/bbht_ctrl.sv
module bbht_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output bbht_pkg::bbht_cmd_t   cmd,
    input  bbht_pkg::bbht_stat_t  stat
);
    import bbht_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BBOX = 2'd1;
    localparam logic [1:0] ST_TEST = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       mv_reg, mv_next, hit_reg, hit_next;

    logic out_free;
    assign out_free = !mv_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        hit_next   = hit_reg;
        cmd        = '0;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_BBOX;
                end
            end
            ST_BBOX: begin
                cmd.bbox   = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (stat.contained || (!stat.disjoint && stat.level_zero)) begin
                    if (out_free) begin
                        mv_next = 1'b1; hit_next = 1'b1; state_next = ST_IDLE;
                    end
                end else if (stat.disjoint) begin
                    if (stat.stack_empty) begin
                        if (out_free) begin
                            mv_next = 1'b1; hit_next = 1'b0; state_next = ST_IDLE;
                        end
                    end else begin
                        cmd.pop = 1'b1; state_next = ST_BBOX;
                    end
                end else begin
                    cmd.split = 1'b1; state_next = ST_BBOX;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            hit_reg   <= hit_next;
        end
    end

    assign m_valid = mv_reg;
    assign m_hit   = hit_reg;
endmodule

FILE: src/bezier_box_hit_test.sv
// Cubic Bezier curve versus rectangle hit test.
// Input channel (s_valid/s_ready): one word carries four control points,
// signed Q15.8. Result channel (m_valid/m_ready): one word, m_hit.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// index 0..4 = box_left, box_bottom, box_right, box_top, depth_limit.
// Write config only while idle.
// Each curve piece goes through two states: bounding box, then test and split or
// pop. At most 511 pieces are visited per curve at depth 8.
// One curve is worked at a time; s_ready is high only when idle.
// The result sits in an output register; a new curve is accepted while it
// waits. If the receiver stalls, the next curve finishes its search and
// holds in the test state until the output register frees.
// Reset (synchronous, aresetn low): box registers 0, depth_limit 8,
// no result pending.
module bezier_box_hit_test #(
    parameter int MAX_LEVEL   = bbht_pkg::MAX_LEVEL_DEF,
    parameter int COORD_WIDTH = bbht_pkg::COORD_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [COORD_WIDTH-1:0]    s_p0_x,
    input  logic signed [COORD_WIDTH-1:0]    s_p0_y,
    input  logic signed [COORD_WIDTH-1:0]    s_p1_x,
    input  logic signed [COORD_WIDTH-1:0]    s_p1_y,
    input  logic signed [COORD_WIDTH-1:0]    s_p2_x,
    input  logic signed [COORD_WIDTH-1:0]    s_p2_y,
    input  logic signed [COORD_WIDTH-1:0]    s_p3_x,
    input  logic signed [COORD_WIDTH-1:0]    s_p3_y,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bbht_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bbht_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bbht_pkg::*;

    logic signed [COORD_WIDTH-1:0] box_left_reg, box_bottom_reg, box_right_reg, box_top_reg;
    logic [LEVEL_W-1:0]            depth_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_left_reg    <= '0;
            box_bottom_reg  <= '0;
            box_right_reg   <= '0;
            box_top_reg     <= '0;
            depth_limit_reg <= LEVEL_W'(8);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BOX_LEFT:    box_left_reg    <= cfg_data[COORD_WIDTH-1:0];
                REG_BOX_BOTTOM:  box_bottom_reg  <= cfg_data[COORD_WIDTH-1:0];
                REG_BOX_RIGHT:   box_right_reg   <= cfg_data[COORD_WIDTH-1:0];
                REG_BOX_TOP:     box_top_reg     <= cfg_data[COORD_WIDTH-1:0];
                REG_DEPTH_LIMIT: depth_limit_reg <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [COORD_WIDTH-1:0] in_pt [8];
    assign in_pt[0] = s_p0_x; assign in_pt[1] = s_p0_y;
    assign in_pt[2] = s_p1_x; assign in_pt[3] = s_p1_y;
    assign in_pt[4] = s_p2_x; assign in_pt[5] = s_p2_y;
    assign in_pt[6] = s_p3_x; assign in_pt[7] = s_p3_y;

    bbht_cmd_t  cmd;
    bbht_stat_t stat;

    bbht_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_hit,
        .cmd, .stat
    );

    bbht_datapath #(.MAX_LEVEL(MAX_LEVEL), .COORD_WIDTH(COORD_WIDTH)) u_dp (
        .aclk, .aresetn, .cmd, .stat, .in_pt,
        .box_left(box_left_reg), .box_bottom(box_bottom_reg),
        .box_right(box_right_reg), .box_top(box_top_reg),
        .depth_limit(depth_limit_reg)
    );
endmodule

FILE: src/bbht_checker.sv
module bbht_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_hit
);
    a_mv_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit))
        else $error("result dropped while stalled");
    a_no_ready_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accept");
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result too early");
    a_reset_clean: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind bezier_box_hit_test bbht_checker u_bbht_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_hit
);

FILE: verif/bezier_box_hit_test_tb.sv
module bezier_box_hit_test_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bbht_pkg::*;

    localparam int CW       = COORD_WIDTH_DEF;
    localparam int MAXL     = MAX_LEVEL_DEF;
    localparam int N_RANDOM = 560;

    typedef logic signed [CW-1:0] coord_t;
    typedef struct {
        coord_t x;
        coord_t y;
    } point_t;
    typedef point_t curve_t [4];

    // one row of the directed table; want_hit < 0 means "ask the predictor"
    typedef struct {
        coord_t c [8];
        int     want_hit;
    } vec_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    coord_t      s_p0_x = '0, s_p0_y = '0, s_p1_x = '0, s_p1_y = '0;
    coord_t      s_p2_x = '0, s_p2_y = '0, s_p3_x = '0, s_p3_y = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_hit;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bezier_box_hit_test uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_p0_x(s_p0_x), .s_p0_y(s_p0_y), .s_p1_x(s_p1_x), .s_p1_y(s_p1_y),
        .s_p2_x(s_p2_x), .s_p2_y(s_p2_y), .s_p3_x(s_p3_x), .s_p3_y(s_p3_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // mirror of the rectangle and depth registers
    coord_t     rect_lo_x = '0, rect_lo_y = '0, rect_hi_x = '0, rect_hi_y = '0;
    logic [3:0] depth_lim = 4'd8;

    logic       hit_queue [$];
    int         n_err = 0;
    bit         quiet_tail = 1'b0;   // no idling in the last part of the run
    bit         stall_long = 1'b0;   // receiver holds off to back up the block

    // floor((a+b)/2) computed at CW+1 bits, always in range
    function automatic coord_t half_sum(coord_t a, coord_t b);
        logic signed [CW:0] s;
        s = $signed({a[CW-1], a}) + $signed({b[CW-1], b});
        return s[CW:1];
    endfunction

    function automatic point_t mid_pt(point_t a, point_t b);
        point_t r;
        r.x = half_sum(a.x, b.x);
        r.y = half_sum(a.y, b.y);
        return r;
    endfunction

    // 0 disjoint, 1 contained, 2 straddles
    function automatic int box_class(curve_t c);
        coord_t x0, x1, y0, y1;
        x0 = c[0].x; x1 = c[0].x; y0 = c[0].y; y1 = c[0].y;
        for (int i = 1; i < 4; i++) begin
            if (c[i].x < x0) x0 = c[i].x;
            if (c[i].x > x1) x1 = c[i].x;
            if (c[i].y < y0) y0 = c[i].y;
            if (c[i].y > y1) y1 = c[i].y;
        end
        if (x1 < rect_lo_x || rect_hi_x < x0 || y1 < rect_lo_y || rect_hi_y < y0)
            return 0;
        if (rect_lo_x <= x0 && x1 <= rect_hi_x && rect_lo_y <= y0 && y1 <= rect_hi_y)
            return 1;
        return 2;
    endfunction

    // depth-first subdivision search, left half first
    function automatic logic curve_hits(curve_t start);
        curve_t cur, stk [MAXL];
        int     lvl_stk [MAXL];
        int     lvl, sp, cls;
        point_t a, b, d, e, f, g;
        cur = start;
        lvl = (depth_lim > MAXL) ? MAXL : depth_lim;
        sp = 0;
        forever begin
            cls = box_class(cur);
            if (cls == 1 || (cls == 2 && lvl == 0)) return 1'b1;
            if (cls == 0) begin
                if (sp == 0) return 1'b0;
                sp--;
                cur = stk[sp];
                lvl = lvl_stk[sp];
                continue;
            end
            a = mid_pt(cur[0], cur[1]);
            b = mid_pt(cur[1], cur[2]);
            d = mid_pt(cur[2], cur[3]);
            e = mid_pt(a, b);
            f = mid_pt(b, d);
            g = mid_pt(e, f);
            lvl--;
            if (sp < MAXL) begin
                stk[sp][0] = g; stk[sp][1] = f; stk[sp][2] = d; stk[sp][3] = cur[3];
                lvl_stk[sp] = lvl & 15;
                sp++;
            end
            cur[1] = a; cur[2] = e; cur[3] = g;
        end
    endfunction

    // cfg_valid stays high between back-to-back writes; set_rect drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_BOX_LEFT:    rect_lo_x = val[CW-1:0];
            REG_BOX_BOTTOM:  rect_lo_y = val[CW-1:0];
            REG_BOX_RIGHT:   rect_hi_x = val[CW-1:0];
            REG_BOX_TOP:     rect_hi_y = val[CW-1:0];
            REG_DEPTH_LIMIT: depth_lim = val[3:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // drop s_valid, then wait until every result is in
    task automatic drain();
        s_valid <= 1'b0;
        while (hit_queue.size() != 0) @(negedge aclk);
        repeat (1100) @(negedge aclk);
    endtask

    task automatic set_rect(coord_t lx, coord_t ly, coord_t hx, coord_t hy, int lim);
        drain();
        write_reg(REG_BOX_LEFT,   CFG_DATA_W'(lx));
        write_reg(REG_BOX_BOTTOM, CFG_DATA_W'(ly));
        write_reg(REG_BOX_RIGHT,  CFG_DATA_W'(hx));
        write_reg(REG_BOX_TOP,    CFG_DATA_W'(hy));
        write_reg(REG_DEPTH_LIMIT, CFG_DATA_W'(lim));
        cfg_valid <= 1'b0;
    endtask

    // send one curve; called at a falling edge, returns at a falling edge
    // with s_valid still high; drain() drops it
    task automatic send_curve(coord_t c [8], int want_hit);
        curve_t cv;
        logic   exp_hit;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        for (int i = 0; i < 4; i++) begin
            cv[i].x = c[2*i];
            cv[i].y = c[2*i+1];
        end
        exp_hit = curve_hits(cv);
        if (want_hit >= 0 && exp_hit !== want_hit[0])
            $display("table row disagrees with predictor: row %0d pred %0d", want_hit, exp_hit);
        s_p0_x <= c[0]; s_p0_y <= c[1]; s_p1_x <= c[2]; s_p1_y <= c[3];
        s_p2_x <= c[4]; s_p2_y <= c[5]; s_p3_x <= c[6]; s_p3_y <= c[7];
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        hit_queue.push_back(want_hit >= 0 ? want_hit[0] : exp_hit);
        @(negedge aclk);
    endtask

    function automatic coord_t rnd_near(int span);
        int v;
        v = $urandom_range(0, 2 * span) - span;
        return coord_t'(v);
    endfunction

    // result side: random stalls, checked at the rising edge
    initial begin
        forever begin
            @(negedge aclk);
            if (stall_long) begin
                m_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (hit_queue.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result word hit=%0b", m_hit);
            end else begin
                logic want;
                want = hit_queue.pop_front();
                if (m_hit !== want) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("hit mismatch: expected %0b got %0b", want, m_hit);
                end
            end
        end
    end

    // long receiver hold-off, counted in its own process
    initial begin
        wait (aresetn);
        repeat (3000) @(negedge aclk);
        stall_long = 1'b1;
        repeat (6000) @(negedge aclk);
        stall_long = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    localparam coord_t CMAX = 24'sh7fffff;
    localparam coord_t CMIN = -24'sh800000;

    vec_row_t table_rows [$];
    coord_t   c [8];

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // after reset: degenerate rectangle at origin, depth 8
        table_rows = '{
            '{'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, 1},
            '{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 0},
            '{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 0},
            '{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, -1},
            '{'{CMIN, 24'sd0, CMIN, 24'sd0, CMAX, 24'sd0, CMAX, 24'sd0}, -1},
            '{'{-24'sd256, -24'sd256, 24'sd256, 24'sd256, 24'sd256, -24'sd256,
                -24'sd256, 24'sd256}, -1}
        };
        foreach (table_rows[i]) send_curve(table_rows[i].c, table_rows[i].want_hit);

        // full-range rectangle: everything is inside
        set_rect(CMIN, CMIN, CMAX, CMAX, 0);
        table_rows = '{
            '{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1},
            '{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1}
        };
        foreach (table_rows[i]) send_curve(table_rows[i].c, table_rows[i].want_hit);

        // inverted rectangle; depth limit above the stack depth saturates
        set_rect(24'sd1000, 24'sd1000, -24'sd1000, -24'sd1000, 15);
        table_rows = '{
            '{'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, 0},
            '{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, -1}
        };
        foreach (table_rows[i]) send_curve(table_rows[i].c, table_rows[i].want_hit);

        // small rectangle in a corner gap, deep search
        set_rect(24'sd100, 24'sd100, 24'sd140, 24'sd140, 15);
        table_rows = '{
            '{'{24'sd0, 24'sd0, 24'sd0, 24'sd512, 24'sd512, 24'sd512, 24'sd512,
                24'sd0}, -1},
            '{'{24'sd0, 24'sd0, 24'sd400, 24'sd400, -24'sd400, 24'sd400, 24'sd0,
                24'sd0}, -1},
            '{'{CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN}, -1},
            '{'{24'sd120, 24'sd120, 24'sd120, 24'sd120, 24'sd120, 24'sd120,
                24'sd120, 24'sd120}, 1},
            '{'{-24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1,
                -24'sd1}, 0}
        };
        foreach (table_rows[i]) send_curve(table_rows[i].c, table_rows[i].want_hit);

        // random phases with varied rectangle and depth
        for (int ph = 0; ph < 8; ph++) begin
            int span, lim;
            coord_t lx, ly;
            span = (ph == 7) ? 8388607 : (1 << (8 + 2 * ph));
            lim = (ph == 0) ? 0 : (ph == 1) ? MAXL : $urandom_range(0, 15);
            lx = rnd_near(span / 2);
            ly = rnd_near(span / 2);
            if (ph == 7) begin
                lx = CMIN;
                ly = CMIN;
            end
            set_rect(lx, ly,
                     (ph == 7) ? CMAX : coord_t'(lx + $urandom_range(0, span / 2)),
                     (ph == 7) ? CMAX : coord_t'(ly + $urandom_range(0, span / 2)),
                     lim);
            if (ph == 7) quiet_tail = 1'b1;
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // raw bits, covers every bit of every field
                    foreach (c[k]) c[k] = coord_t'($urandom());
                end else begin
                    foreach (c[k]) c[k] = rnd_near(span);
                end
                send_curve(c, -1);
            end
        end

        drain();
        if (n_err == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

FILE: files.f
src/bbht_pkg.sv
src/bbht_datapath.sv
src/bbht_ctrl.sv
src/bezier_box_hit_test.sv
src/bbht_checker.sv
verif/bezier_box_hit_test_tb.sv
